[rtl/ole_pkg.sv]
`default_nettype none

package ole_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Request opcodes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_APPEND   = 2'd0;
    localparam t_cmd CMD_DELETE   = 2'd1;
    localparam t_cmd CMD_TRAVERSE = 2'd2;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load;        // capture request fields, clear index
        logic    rd;          // registered memory read
        logic    rd_next;     // read at index + 1 instead of index
        logic    wr_append;   // write value at tail, count + 1
        logic    wr_shift;    // write read data at index
        logic    idx_inc;     // index + 1
        logic    cnt_dec;     // count - 1
        logic    out_load;    // load output register
        logic    out_data;    // result value from read data, else zero
        t_status out_status;
        logic    out_last;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        t_cmd cmd;
        logic cnt_zero;
        logic cnt_full;
        logic match;
        logic at_tail;        // index + 1 == count
        logic out_free;       // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/ole_req_if.sv]
`default_nettype none

interface ole_req_if;
    import ole_pkg::*;

    logic        valid;
    logic        ready;
    t_cmd        cmd;
    logic [31:0] item_value;

    modport source (output valid, output cmd, output item_value, input ready);
    modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

`default_nettype wire

[rtl/ole_rsp_if.sv]
`default_nettype none

interface ole_rsp_if;
    import ole_pkg::*;

    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    t_status     status;
    logic        last;

    modport source (output valid, output result_value, output status, output last,
                    input ready);
    modport sink   (input valid, input result_value, input status, input last,
                    output ready);
endinterface

`default_nettype wire

[rtl/ole_datapath.sv]
`default_nettype none

module ole_datapath
    import ole_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_ctl,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_item_value,
    input  wire logic        i_out_ready,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic [31:0]      o_result_value,
    output t_status          o_status,
    output logic             o_last
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_cmd                  r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic [IW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_mem [LIST_DEPTH];

    logic                  r_out_valid;
    logic [31:0]           r_out_value;
    t_status               r_out_status;
    logic                  r_out_last;

    logic [IW-1:0]         idx_next;
    logic [IW-1:0]         rd_addr;

    assign idx_next = r_idx + IW'(1);
    assign rd_addr  = i_ctl.rd_next ? idx_next : r_idx;

    // request capture and index
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_val <= DATA_WIDTH'(i_item_value);
            r_idx <= '0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= idx_next;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.wr_append) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // list storage: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_append) begin
            r_mem[r_count[IW-1:0]] <= r_val;
        end else if (i_ctl.wr_shift) begin
            r_mem[r_idx] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_value  <= i_ctl.out_data ? 32'($signed(r_rdata)) : 32'd0;
            r_out_status <= i_ctl.out_status;
            r_out_last   <= i_ctl.out_last;
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.cnt_full = (r_count == CW'(LIST_DEPTH));
    assign o_sts.match    = (r_rdata == r_val);
    assign o_sts.at_tail  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

[rtl/ole_ctrl.sv]
`default_nettype none

module ole_ctrl
    import ole_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_ctl
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_SRCH_RD   = 9'b000000100,
        S_SRCH_CMP  = 9'b000001000,
        S_SHIFT_RD  = 9'b000010000,
        S_SHIFT_WR  = 9'b000100000,
        S_TRAV_RD   = 9'b001000000,
        S_TRAV_EMIT = 9'b010000000,
        S_REPLY     = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_ctl      = '0;
        o_ctl.load = o_req_ready && i_req_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_APPEND: begin
                        n_state = S_REPLY;
                        if (i_sts.cnt_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ctl.wr_append = 1'b1;
                            n_status        = ST_OK;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_sts.cnt_zero) begin
                            n_status = ST_EMPTY;
                            n_state  = S_REPLY;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    CMD_TRAVERSE: begin
                        if (i_sts.cnt_zero) begin
                            n_status = ST_EMPTY;
                            n_state  = S_REPLY;
                        end else begin
                            n_state = S_TRAV_RD;
                        end
                    end
                    default: n_state = S_IDLE;  // unused opcode: no result
                endcase
            end
            S_SRCH_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_sts.match) begin
                    n_state = S_SHIFT_RD;
                end else if (i_sts.at_tail) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_REPLY;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                // gap reached the tail: drop the last slot
                if (i_sts.at_tail) begin
                    o_ctl.cnt_dec = 1'b1;
                    n_status      = ST_OK;
                    n_state       = S_REPLY;
                end else begin
                    o_ctl.rd      = 1'b1;
                    o_ctl.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_ctl.wr_shift = 1'b1;
                o_ctl.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_TRAV_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_TRAV_EMIT;
            end
            S_TRAV_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_data   = 1'b1;
                    o_ctl.out_status = ST_OK;
                    o_ctl.out_last   = i_sts.at_tail;
                    if (i_sts.at_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = S_TRAV_RD;
                    end
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_status = r_status;
                    o_ctl.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> i_sts.out_free)
        else $error("output register loaded while occupied");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.wr_append |-> !i_sts.cnt_full)
        else $error("append into a full list");

    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.cnt_dec |-> !i_sts.cnt_zero)
        else $error("count decremented below zero");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.wr_append && o_ctl.wr_shift))
        else $error("two memory writes in one cycle");

endmodule

`default_nettype wire

[rtl/ordered_list_engine_core.sv]
// Ordered list engine: a packed list of up to LIST_DEPTH signed values, head first.
// Request channel (i_req): cmd and item_value. Append adds after the tail, delete
// removes the first equal entry and closes the gap, traverse walks head to tail.
// Response channel (o_rsp): result_value, status and last. Append and delete give
// one response; traverse gives one per entry (last on the tail) or one empty status.
// Opcode 3 is taken and dropped with no response.
// Timing: one request is worked at a time; i_req.ready is high while idle.
//   append / empty / full: decoded in the dispatch state, response registered in
//   the reply state. delete: a read and a compare state per entry searched, then a
//   read and a write state per entry shifted, set by the list memory with its
//   registered read.
//   traverse: per entry, a read, then a load of the output register.
// Reset clears the entry count and the output valid; list storage is not cleared,
// slots at or above the count are never read.
// A stalled receiver holds the output register; the engine waits before the next
// response but still takes a new request once the current one is done.
`default_nettype none

module ordered_list_engine_core
    import ole_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ole_req_if.sink   i_req,
    ole_rsp_if.source o_rsp
);

    t_dp_cmd ctl;
    t_dp_sts sts;

    // sequencer: decodes the request, steps search / shift / walk
    ole_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // list memory, count, index, compare and output register
    ole_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cmd          (i_req.cmd),
        .i_item_value   (i_req.item_value),
        .i_out_ready    (o_rsp.ready),
        .o_sts          (sts),
        .o_out_valid    (o_rsp.valid),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_last         (o_rsp.last)
    );

endmodule

`default_nettype wire
